FILE: rtl/core/brd_pkg.sv
// brd_pkg: shared types and constants for the button release debouncer.
// No dependencies; imported by the interfaces and every module in rtl/core.
package brd_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int COUNT_W     = 8;

    localparam logic [COUNT_W-1:0] DELAY_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_CLR_ONE  = 2'd1,
        OP_CLR_LANE = 2'd2
    } op_t;

    // per-button control for one accepted beat
    typedef struct packed {
        logic tick;
        logic clr;
        logic pin;
    } btn_ctrl_t;

    // per-button state after the beat
    typedef struct packed {
        logic stable;
        logic flag;
    } btn_stat_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] release_flags;
        logic                   lane0_released;
        logic                   lane1_released;
        logic [NUM_BUTTONS-1:0] stable_levels;
    } result_t;

endpackage

FILE: rtl/core/brd_if.sv
// brd_if: valid/ready channel interfaces for items, results and config writes.
// Depends on brd_pkg.
interface brd_item_if
    import brd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             op;
    logic [NUM_BUTTONS-1:0] pin_levels;
    logic [1:0]             btn_sel;
    logic                   lane;

    modport source (output valid, op, pin_levels, btn_sel, lane, input ready);
    modport sink   (input valid, op, pin_levels, btn_sel, lane, output ready);
endinterface

interface brd_result_if
    import brd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] release_flags;
    logic                   lane0_released;
    logic                   lane1_released;
    logic [NUM_BUTTONS-1:0] stable_levels;

    modport source (output valid, release_flags, lane0_released, lane1_released,
                    stable_levels, input ready);
    modport sink   (input valid, release_flags, lane0_released, lane1_released,
                    stable_levels, output ready);
endinterface

interface brd_cfg_if
    import brd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/button_release_debouncer.sv
// button_release_debouncer: four-button release debouncer, top level.
// Depends on brd_pkg, brd_if, brd_button, brd_result.
//
//   channel  role  payload                                          beat
//   item     sink  op, pin_levels, btn_sel, lane                    valid & ready
//   result   src   release_flags, lane0/1_released, stable_levels   valid & ready
//   cfg      sink  data (bounce delay in samples)                   valid & ready
//
// One item per cycle unless stalled; registered result shows the next cycle.
// The button state and the result register update on the same accepting edge.
// Reset: levels released, counters and flags cleared, delay 3; no result held.
// A stalled result blocks the item channel only while it is held and not taken.
// cfg is always ready.
module button_release_debouncer
    import brd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    brd_item_if.sink      item,
    brd_result_if.source  result,
    brd_cfg_if.sink       cfg
);

    logic [COUNT_W-1:0]     delay_reg;
    logic                   accept;
    logic                   space;
    btn_ctrl_t              ctrl [NUM_BUTTONS];
    btn_stat_t              stat [NUM_BUTTONS];
    result_t                res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_RESET;
        else if (cfg.valid)
            delay_reg <= cfg.data;
    end

    assign cfg.ready  = 1'b1;
    assign item.ready = space;
    assign accept     = item.valid && space;

    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_btn
        always_comb
        begin
            ctrl[b].pin  = item.pin_levels[b];
            ctrl[b].tick = 1'b0;
            ctrl[b].clr  = 1'b0;
            unique case (op_t'(item.op))
                OP_TICK:     ctrl[b].tick = 1'b1;
                OP_CLR_ONE:  ctrl[b].clr  = (item.btn_sel == 2'(b));
                OP_CLR_LANE: ctrl[b].clr  = (item.lane == 1'(b));
                default:     ;
            endcase
        end

        brd_button u_button (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .ctrl  (ctrl[b]),
            .delay (delay_reg),
            .stat  (stat[b])
        );

        assign res.release_flags[b] = stat[b].flag;
        assign res.stable_levels[b] = stat[b].stable;
    end

    assign res.lane0_released = res.release_flags[0] | res.release_flags[2];
    assign res.lane1_released = res.release_flags[1] | res.release_flags[3];

    brd_result u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .data   (res),
        .space  (space),
        .result (result)
    );

endmodule

FILE: rtl/core/brd_button.sv
// brd_button: one button's stable level, mismatch counter and release flag.
// Depends on brd_pkg.
module brd_button
    import brd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  btn_ctrl_t          ctrl,
    input  logic [COUNT_W-1:0] delay,
    output btn_stat_t          stat
);

    logic               stable_reg, stable_next;
    logic               flag_reg, flag_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               match;
    logic               flip;

    always_comb
    begin
        match       = (ctrl.pin == stable_reg);
        count_inc   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
        flip        = !match && (count_inc >= delay);
        stable_next = stable_reg;
        count_next  = count_reg;
        flag_next   = flag_reg;
        if (ctrl.tick)
        begin
            count_next = (match || flip) ? '0 : count_inc;
            if (flip)
            begin
                stable_next = ctrl.pin;
                // pressed to released
                if (ctrl.pin)
                    flag_next = 1'b1;
            end
        end
        else if (ctrl.clr)
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b1;
            count_reg  <= '0;
            flag_reg   <= 1'b0;
        end
        else if (en)
        begin
            stable_reg <= stable_next;
            count_reg  <= count_next;
            flag_reg   <= flag_next;
        end
    end

    assign stat.stable = stable_next;
    assign stat.flag   = flag_next;

endmodule

FILE: rtl/core/brd_result.sv
// brd_result: result register stage toward the result channel.
// Depends on brd_pkg and brd_result_if.
module brd_result
    import brd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  result_t         data,
    output logic            space,
    brd_result_if.source    result
);

    logic    valid_reg;
    result_t data_reg;

    assign space = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign result.valid          = valid_reg;
    assign result.release_flags  = data_reg.release_flags;
    assign result.lane0_released = data_reg.lane0_released;
    assign result.lane1_released = data_reg.lane1_released;
    assign result.stable_levels  = data_reg.stable_levels;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("result not valid after load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result.ready) |-> !load)
        else $error("stalled result overwritten");

    a_load_data: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (data_reg == $past(data)))
        else $error("result register lost loaded beat");

    a_lane_or: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.lane0_released ==
                       (data_reg.release_flags[0] | data_reg.release_flags[2]))
                   && (data_reg.lane1_released ==
                       (data_reg.release_flags[1] | data_reg.release_flags[3])))
        else $error("lane OR mismatch");

endmodule
